### rtl/tbce_pkg.sv
// Shared constants, register indexes and the configuration record of the crossover block.
package tbce_pkg;

  // Default widths of the sample path and of the filter accumulators.
  localparam int SAMPLE_BITS_DEF = 24;
  localparam int ACC_BITS_DEF    = 40;

  // Fixed number formats.
  localparam int COEF_FRAC   = 30;
  localparam int MUL_A_BITS  = 34;
  localparam int LEVEL_BITS  = 16;
  localparam logic [LEVEL_BITS-1:0] LEVEL_ONE = 16'd32768;
  localparam int SCALE_SHIFT = 32;

  // Configuration port format.
  localparam int CFG_IDX_BITS  = 8;
  localparam int CFG_DATA_BITS = 64;

  // Register indexes.
  localparam logic [CFG_IDX_BITS-1:0] REG_UPPER_NUMER = 8'd0;
  localparam logic [CFG_IDX_BITS-1:0] REG_UPPER_DENOM = 8'd1;
  localparam logic [CFG_IDX_BITS-1:0] REG_LOWER_NUMER = 8'd2;
  localparam logic [CFG_IDX_BITS-1:0] REG_LOWER_DENOM = 8'd3;
  localparam logic [CFG_IDX_BITS-1:0] REG_ATTACK      = 8'd4;
  localparam logic [CFG_IDX_BITS-1:0] REG_RELEASE     = 8'd5;
  localparam logic [CFG_IDX_BITS-1:0] REG_PEAK_DECAY  = 8'd6;
  localparam logic [CFG_IDX_BITS-1:0] REG_NOISE_FLOOR = 8'd7;

  // Reset values of the smoothing registers and the noise floor.
  localparam logic [31:0] ATTACK_RESET      = 32'd4277108822;
  localparam logic [31:0] RELEASE_RESET     = 32'd4294370815;
  localparam logic [31:0] PEAK_DECAY_RESET  = 32'd4294964195;
  localparam logic [22:0] NOISE_FLOOR_RESET = 23'd4194;

  // Register contents as seen by the datapath.
  typedef struct packed {
    logic [63:0] upper_numer;
    logic [63:0] upper_denom;
    logic [63:0] lower_numer;
    logic [63:0] lower_denom;
    logic [31:0] attack_coeff;
    logic [31:0] release_coeff;
    logic [31:0] peak_decay_coeff;
    logic [22:0] noise_floor;
  } cfg_t;

endpackage

### rtl/tbce_if.sv
// Valid/ready channel interfaces for samples, band levels and register writes.
interface tbce_sample_if #(
  parameter int SAMPLE_BITS = tbce_pkg::SAMPLE_BITS_DEF
);
  logic                          valid;
  logic                          ready;
  logic signed [SAMPLE_BITS-1:0] sample;
  modport source (output valid, output sample, input ready);
  modport sink (input valid, input sample, output ready);
endinterface

interface tbce_level_if;
  logic                              valid;
  logic                              ready;
  logic [tbce_pkg::LEVEL_BITS-1:0]   low_level;
  logic [tbce_pkg::LEVEL_BITS-1:0]   mid_level;
  logic [tbce_pkg::LEVEL_BITS-1:0]   high_level;
  modport source (output valid, output low_level, output mid_level, output high_level,
                  input ready);
  modport sink (input valid, input low_level, input mid_level, input high_level,
                output ready);
endinterface

interface tbce_cfg_if;
  logic                                valid;
  logic                                ready;
  logic [tbce_pkg::CFG_IDX_BITS-1:0]   index;
  logic [tbce_pkg::CFG_DATA_BITS-1:0]  data;
  modport source (output valid, output index, output data, input ready);
  modport sink (input valid, input index, input data, output ready);
endinterface

### rtl/tbce_regs.sv
// Configuration register file written through the register channel.
module tbce_regs (
  input  logic           clk_i,
  input  logic           rst_ni,
  tbce_cfg_if.sink       cfg_if,
  output tbce_pkg::cfg_t cfg_o
);

  tbce_pkg::cfg_t cfg_q, cfg_d;

  // Writes are always taken; unknown indexes are dropped.
  assign cfg_if.ready = 1'b1;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_if.valid) begin
      case (cfg_if.index)
        tbce_pkg::REG_UPPER_NUMER: cfg_d.upper_numer      = cfg_if.data;
        tbce_pkg::REG_UPPER_DENOM: cfg_d.upper_denom      = cfg_if.data;
        tbce_pkg::REG_LOWER_NUMER: cfg_d.lower_numer      = cfg_if.data;
        tbce_pkg::REG_LOWER_DENOM: cfg_d.lower_denom      = cfg_if.data;
        tbce_pkg::REG_ATTACK:      cfg_d.attack_coeff     = cfg_if.data[31:0];
        tbce_pkg::REG_RELEASE:     cfg_d.release_coeff    = cfg_if.data[31:0];
        tbce_pkg::REG_PEAK_DECAY:  cfg_d.peak_decay_coeff = cfg_if.data[31:0];
        tbce_pkg::REG_NOISE_FLOOR: cfg_d.noise_floor      = cfg_if.data[22:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.upper_numer      <= '0;
      cfg_q.upper_denom      <= '0;
      cfg_q.lower_numer      <= '0;
      cfg_q.lower_denom      <= '0;
      cfg_q.attack_coeff     <= tbce_pkg::ATTACK_RESET;
      cfg_q.release_coeff    <= tbce_pkg::RELEASE_RESET;
      cfg_q.peak_decay_coeff <= tbce_pkg::PEAK_DECAY_RESET;
      cfg_q.noise_floor      <= tbce_pkg::NOISE_FLOOR_RESET;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

### rtl/tbce_serial_mult.sv
// Bit-serial signed multiplier: one multiplier bit per cycle, shift-and-add.
module tbce_serial_mult #(
  parameter int AW = tbce_pkg::MUL_A_BITS,
  parameter int BW = tbce_pkg::SAMPLE_BITS_DEF + 1
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   start_i,
  input  logic signed [AW-1:0]   a_i,
  input  logic signed [BW-1:0]   b_i,
  output logic                   done_o,
  output logic signed [AW+BW:0]  prod_o
);

  localparam int CW = $clog2(BW);

  logic              busy_q, busy_d;
  logic              done_q, done_d;
  logic [CW-1:0]     cnt_q, cnt_d;
  logic signed [AW-1:0] a_q, a_d;
  logic signed [AW:0]   hi_q, hi_d;
  logic [BW-1:0]     lo_q, lo_d;
  logic signed [AW:0]   a_ext, addend, sum;
  logic              last;

  // One partial product per cycle; the sign bit of the multiplier subtracts.
  always_comb begin
    last   = (cnt_q == CW'(BW - 1));
    a_ext  = {a_q[AW-1], a_q};
    addend = lo_q[0] ? (last ? -a_ext : a_ext) : '0;
    sum    = hi_q + addend;
    busy_d = busy_q;
    done_d = 1'b0;
    cnt_d  = cnt_q;
    a_d    = a_q;
    hi_d   = hi_q;
    lo_d   = lo_q;
    if (start_i && !busy_q) begin
      busy_d = 1'b1;
      cnt_d  = '0;
      a_d    = a_i;
      hi_d   = '0;
      lo_d   = b_i;
    end else if (busy_q) begin
      hi_d  = {sum[AW], sum[AW:1]};
      lo_d  = {sum[0], lo_q[BW-1:1]};
      cnt_d = cnt_q + 1'b1;
      if (last) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    a_q  <= a_d;
    hi_q <= hi_d;
    lo_q <= lo_d;
  end

  assign done_o = done_q;
  assign prod_o = {hi_q, lo_q};

endmodule

### rtl/tbce_serial_div.sv
// Restoring divider producing one quotient bit per cycle for the level ratio.
module tbce_serial_div #(
  parameter int DW = tbce_pkg::SAMPLE_BITS_DEF + 3
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            start_i,
  input  logic [DW-1:0]                   num_i,
  input  logic [DW-1:0]                   den_i,
  output logic                            done_o,
  output logic [tbce_pkg::LEVEL_BITS-1:0] quo_o
);

  localparam int QB = tbce_pkg::LEVEL_BITS;
  localparam int CW = $clog2(QB);

  logic          busy_q, busy_d;
  logic          done_q, done_d;
  logic [CW-1:0] cnt_q, cnt_d;
  logic [DW-1:0] rem_q, rem_d;
  logic [DW-1:0] den_q, den_d;
  logic [QB-1:0] quo_q, quo_d;
  logic [DW:0]   rem2;
  logic          ge;

  // The numerator's low quotient bits are zero, so only the remainder doubles.
  always_comb begin
    rem2   = {rem_q, 1'b0};
    ge     = (rem2 >= {1'b0, den_q});
    busy_d = busy_q;
    done_d = 1'b0;
    cnt_d  = cnt_q;
    rem_d  = rem_q;
    den_d  = den_q;
    quo_d  = quo_q;
    if (start_i && !busy_q) begin
      busy_d = 1'b1;
      cnt_d  = '0;
      rem_d  = num_i;
      den_d  = den_i;
      quo_d  = '0;
    end else if (busy_q) begin
      rem_d = ge ? DW'(rem2 - {1'b0, den_q}) : rem2[DW-1:0];
      quo_d = {quo_q[QB-2:0], ge};
      cnt_d = cnt_q + 1'b1;
      if (cnt_q == CW'(QB - 1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q <= rem_d;
    den_q <= den_d;
    quo_q <= quo_d;
  end

  assign done_o = done_q;
  assign quo_o  = quo_q;

endmodule

### rtl/three_band_crossover_envelope.sv
// Each item takes 33 serial multiplies on the shared multiplier and three divisions, one per band,
// plus control steps, from acceptance to valid levels.
// A band whose peak is zero or under the noise floor skips its division and reads level zero.
// The shared multiplier limits throughput; a new item is taken only once the previous item's levels
// sit in the output register.
// Reset clears filter history, envelopes, peaks and control; registers take their defaults.
module three_band_crossover_envelope #(
  parameter int SAMPLE_BITS = tbce_pkg::SAMPLE_BITS_DEF,
  parameter int ACC_BITS    = tbce_pkg::ACC_BITS_DEF
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  tbce_cfg_if.sink      cfg_if,
  tbce_sample_if.sink   sample_if,
  tbce_level_if.source  level_if
);

  localparam int SB    = SAMPLE_BITS;
  localparam int F     = ACC_BITS - SAMPLE_BITS - 3;
  localparam int K     = tbce_pkg::COEF_FRAC - F;
  localparam int FP    = (F > 0) ? F : 0;
  localparam int FN    = (F < 0) ? -F : 0;
  localparam int ROUND = (F > 0) ? (1 << (FP - 1)) : 0;
  localparam int AW    = tbce_pkg::MUL_A_BITS;
  localparam int BW    = SB + 1;
  localparam int PW    = AW + BW + 1;
  localparam int WW    = PW + 3;
  localparam int RW    = ACC_BITS + FN + 1;
  localparam int DW    = SB + 3;
  localparam int LB    = tbce_pkg::LEVEL_BITS;
  localparam int SS    = tbce_pkg::SCALE_SHIFT;

  localparam logic [3:0] S_IDLE = 4'd0;
  localparam logic [3:0] S_BX   = 4'd1;
  localparam logic [3:0] S_ACC  = 4'd2;
  localparam logic [3:0] S_Y    = 4'd3;
  localparam logic [3:0] S_FB1  = 4'd4;
  localparam logic [3:0] S_FB2  = 4'd5;
  localparam logic [3:0] S_ENV1 = 4'd6;
  localparam logic [3:0] S_ENV2 = 4'd7;
  localparam logic [3:0] S_PK   = 4'd8;
  localparam logic [3:0] S_DIV  = 4'd9;
  localparam logic [3:0] S_DIVW = 4'd10;
  localparam logic [3:0] S_DONE = 4'd11;

  tbce_pkg::cfg_t cfg;

  logic [3:0]             state_q, state_d;
  logic [2:0]             bq_q, bq_d;
  logic [1:0]             band_q, band_d;
  logic                   started_q, started_d;
  logic signed [SB-1:0]   x_q, x_d;
  logic signed [SB-1:0]   lowmid_q, lowmid_d;
  logic signed [SB-1:0]   y_q, y_d;
  logic signed [SB-1:0]   band_y_q [3];
  logic signed [SB-1:0]   band_y_d [3];
  logic signed [WW-1:0]   bx_q, bx_d;
  logic signed [ACC_BITS-1:0] acc_q, acc_d;
  logic signed [ACC_BITS-1:0] s1_q [8];
  logic signed [ACC_BITS-1:0] s1_d [8];
  logic signed [ACC_BITS-1:0] s2_q [8];
  logic signed [ACC_BITS-1:0] s2_d [8];
  logic [SB-1:0]          env_q [3];
  logic [SB-1:0]          env_d [3];
  logic [SB-1:0]          peak_q [3];
  logic [SB-1:0]          peak_d [3];
  logic [SB-1:0]          r_q, r_d;
  logic [31:0]            c_q, c_d;
  logic [PW-1:0]          p1_q, p1_d;
  logic [LB-1:0]          lvl_q [3];
  logic [LB-1:0]          lvl_d [3];
  logic                   out_valid_q, out_valid_d;
  logic [LB-1:0]          out_low_q, out_low_d;
  logic [LB-1:0]          out_mid_q, out_mid_d;
  logic [LB-1:0]          out_high_q, out_high_d;

  logic                   mul_start, mul_done;
  logic signed [AW-1:0]   mul_a;
  logic signed [BW-1:0]   mul_b;
  logic signed [PW-1:0]   mul_p;
  logic                   div_start, div_done;
  logic [DW-1:0]          div_num, div_den;
  logic [LB-1:0]          div_quo;

  logic [63:0]            numer, denom;
  logic                   hp;
  logic signed [31:0]     b0, a1, a2;
  logic signed [SB-1:0]   bq_in;
  logic signed [WW-1:0]   scaled;
  logic signed [WW-1:0]   t1;
  logic signed [RW-1:0]   rnd_v;
  logic signed [SB-1:0]   band_y;
  logic [SB-1:0]          r_abs;
  logic [31:0]            c_sel;
  logic [32:0]            c_comp;
  logic [PW:0]            env_sum;
  logic [SB-1:0]          env_new, decayed, pk_cur;
  logic                   floor_low;

  tbce_regs u_regs (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .cfg_if (cfg_if),
    .cfg_o  (cfg)
  );

  tbce_serial_mult #(.AW(AW), .BW(BW)) u_mult (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (mul_start),
    .a_i     (mul_a),
    .b_i     (mul_b),
    .done_o  (mul_done),
    .prod_o  (mul_p)
  );

  tbce_serial_div #(.DW(DW)) u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (div_start),
    .num_i   (div_num),
    .den_i   (div_den),
    .done_o  (div_done),
    .quo_o   (div_quo)
  );

  // Clamp a wide signed value to the accumulator range.
  function automatic logic signed [ACC_BITS-1:0] sat_acc(input logic signed [WW-1:0] v);
    logic signed [WW-1:0] hi_lim;
    logic signed [WW-1:0] lo_lim;
    hi_lim = (WW'(1) << (ACC_BITS - 1)) - WW'(1);
    lo_lim = -hi_lim - WW'(1);
    if (v > hi_lim) begin
      return hi_lim[ACC_BITS-1:0];
    end else if (v < lo_lim) begin
      return lo_lim[ACC_BITS-1:0];
    end
    return v[ACC_BITS-1:0];
  endfunction

  // Clamp a rounded accumulator to the sample range.
  function automatic logic signed [SB-1:0] sat_smp(input logic signed [RW-1:0] v);
    logic signed [RW-1:0] hi_lim;
    logic signed [RW-1:0] lo_lim;
    hi_lim = (RW'(1) << (SB - 1)) - RW'(1);
    lo_lim = -hi_lim - RW'(1);
    if (v > hi_lim) begin
      return hi_lim[SB-1:0];
    end else if (v < lo_lim) begin
      return lo_lim[SB-1:0];
    end
    return v[SB-1:0];
  endfunction

  // Coefficient selection: biquads 0..3 use the upper crossover, odd pairs are highpass.
  always_comb begin
    numer  = bq_q[2] ? cfg.lower_numer : cfg.upper_numer;
    denom  = bq_q[2] ? cfg.lower_denom : cfg.upper_denom;
    hp     = bq_q[1];
    b0     = hp ? signed'(numer[31:0]) : signed'(numer[63:32]);
    a1     = signed'(denom[63:32]);
    a2     = signed'(denom[31:0]);
    bq_in  = bq_q[0] ? y_q : (bq_q[2] ? lowmid_q : x_q);
    scaled = WW'(mul_p) >>> K;
    t1     = hp ? -(bx_q <<< 1) : (bx_q <<< 1);
    rnd_v  = ((RW'(acc_q) + RW'(ROUND)) >>> FP) <<< FN;
  end

  // Envelope operands for the current band.
  always_comb begin
    band_y    = band_y_q[band_q];
    r_abs     = band_y[SB-1] ? SB'(-band_y) : SB'(band_y);
    c_sel     = (r_abs > env_q[band_q]) ? cfg.attack_coeff : cfg.release_coeff;
    c_comp    = {1'b1, 32'd0} - {1'b0, c_q};
    env_sum   = {1'b0, p1_q} + {1'b0, mul_p};
    env_new   = env_sum[SS +: SB];
    decayed   = mul_p[SS +: SB];
    pk_cur    = peak_q[band_q];
    floor_low = ({{(33 - SB){1'b0}}, pk_cur} < {10'd0, cfg.noise_floor});
    div_num   = (DW'(env_q[band_q]) << 2) + DW'(env_q[band_q]);
    div_den   = (DW'(pk_cur) << 3) - DW'(pk_cur);
  end

  // Operands of the shared multiplier for each step.
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    case (state_q)
      S_BX: begin
        mul_a = AW'(b0);
        mul_b = BW'(bq_in);
      end
      S_FB1: begin
        mul_a = AW'(a1);
        mul_b = BW'(y_q);
      end
      S_FB2: begin
        mul_a = AW'(a2);
        mul_b = BW'(y_q);
      end
      S_ENV1: begin
        mul_a = signed'({2'b00, c_sel});
        mul_b = signed'({1'b0, env_q[band_q]});
      end
      S_ENV2: begin
        mul_a = signed'({1'b0, c_comp});
        mul_b = signed'({1'b0, r_q});
      end
      S_PK: begin
        mul_a = signed'({2'b00, cfg.peak_decay_coeff});
        mul_b = signed'({1'b0, pk_cur});
      end
      default: ;
    endcase
  end

  assign mul_start = !started_q &&
                     (state_q == S_BX || state_q == S_FB1 || state_q == S_FB2 ||
                      state_q == S_ENV1 || state_q == S_ENV2 || state_q == S_PK);
  assign div_start = (state_q == S_DIV) && (pk_cur != '0) && !floor_low;

  // Sequencer over the eight biquads and then the three bands.
  always_comb begin
    state_d     = state_q;
    bq_d        = bq_q;
    band_d      = band_q;
    started_d   = started_q;
    x_d         = x_q;
    lowmid_d    = lowmid_q;
    y_d         = y_q;
    band_y_d    = band_y_q;
    bx_d        = bx_q;
    acc_d       = acc_q;
    s1_d        = s1_q;
    s2_d        = s2_q;
    env_d       = env_q;
    peak_d      = peak_q;
    r_d         = r_q;
    c_d         = c_q;
    p1_d        = p1_q;
    lvl_d       = lvl_q;
    out_valid_d = out_valid_q && !level_if.ready;
    out_low_d   = out_low_q;
    out_mid_d   = out_mid_q;
    out_high_d  = out_high_q;
    if (mul_start) begin
      started_d = 1'b1;
    end
    case (state_q)
      S_IDLE: begin
        if (sample_if.valid) begin
          x_d     = sample_if.sample;
          bq_d    = '0;
          state_d = S_BX;
        end
      end
      S_BX: begin
        if (mul_done) begin
          started_d = 1'b0;
          bx_d      = scaled;
          state_d   = S_ACC;
        end
      end
      S_ACC: begin
        acc_d   = sat_acc(bx_q + WW'(s1_q[bq_q]));
        state_d = S_Y;
      end
      S_Y: begin
        y_d     = sat_smp(rnd_v);
        state_d = S_FB1;
      end
      S_FB1: begin
        if (mul_done) begin
          started_d  = 1'b0;
          s1_d[bq_q] = sat_acc(t1 - scaled + WW'(s2_q[bq_q]));
          state_d    = S_FB2;
        end
      end
      S_FB2: begin
        if (mul_done) begin
          started_d  = 1'b0;
          s2_d[bq_q] = sat_acc(bx_q - scaled);
          // Second biquad of each cascade: keep its output.
          if (bq_q[0]) begin
            case (bq_q[2:1])
              2'd0: lowmid_d    = y_q;
              2'd1: band_y_d[2] = y_q;
              2'd2: band_y_d[0] = y_q;
              default: band_y_d[1] = y_q;
            endcase
          end
          if (bq_q == 3'd7) begin
            band_d  = '0;
            state_d = S_ENV1;
          end else begin
            bq_d    = bq_q + 1'b1;
            state_d = S_BX;
          end
        end
      end
      S_ENV1: begin
        if (mul_start) begin
          c_d = c_sel;
          r_d = r_abs;
        end
        if (mul_done) begin
          started_d = 1'b0;
          p1_d      = mul_p;
          state_d   = S_ENV2;
        end
      end
      S_ENV2: begin
        if (mul_done) begin
          started_d     = 1'b0;
          env_d[band_q] = env_new;
          state_d       = S_PK;
        end
      end
      S_PK: begin
        if (mul_done) begin
          started_d      = 1'b0;
          peak_d[band_q] = (env_q[band_q] > decayed) ? env_q[band_q] : decayed;
          state_d        = S_DIV;
        end
      end
      S_DIV: begin
        if (div_start) begin
          state_d = S_DIVW;
        end else begin
          lvl_d[band_q] = '0;
          if (band_q == 2'd2) begin
            state_d = S_DONE;
          end else begin
            band_d  = band_q + 1'b1;
            state_d = S_ENV1;
          end
        end
      end
      S_DIVW: begin
        if (div_done) begin
          lvl_d[band_q] = (div_quo > tbce_pkg::LEVEL_ONE) ? tbce_pkg::LEVEL_ONE : div_quo;
          if (band_q == 2'd2) begin
            state_d = S_DONE;
          end else begin
            band_d  = band_q + 1'b1;
            state_d = S_ENV1;
          end
        end
      end
      S_DONE: begin
        if (!out_valid_q || level_if.ready) begin
          out_valid_d = 1'b1;
          out_low_d   = lvl_q[0];
          out_mid_d   = lvl_q[1];
          out_high_d  = lvl_q[2];
          state_d     = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      bq_q        <= '0;
      band_q      <= '0;
      started_q   <= 1'b0;
      out_valid_q <= 1'b0;
      for (int i = 0; i < 8; i++) begin
        s1_q[i] <= '0;
        s2_q[i] <= '0;
      end
      for (int i = 0; i < 3; i++) begin
        env_q[i]  <= '0;
        peak_q[i] <= '0;
      end
    end else begin
      state_q     <= state_d;
      bq_q        <= bq_d;
      band_q      <= band_d;
      started_q   <= started_d;
      out_valid_q <= out_valid_d;
      s1_q        <= s1_d;
      s2_q        <= s2_d;
      env_q       <= env_d;
      peak_q      <= peak_d;
    end
  end

  always_ff @(posedge clk_i) begin
    x_q        <= x_d;
    lowmid_q   <= lowmid_d;
    y_q        <= y_d;
    band_y_q   <= band_y_d;
    bx_q       <= bx_d;
    acc_q      <= acc_d;
    r_q        <= r_d;
    c_q        <= c_d;
    p1_q       <= p1_d;
    lvl_q      <= lvl_d;
    out_low_q  <= out_low_d;
    out_mid_q  <= out_mid_d;
    out_high_q <= out_high_d;
  end

  assign sample_if.ready     = (state_q == S_IDLE);
  assign level_if.valid      = out_valid_q;
  assign level_if.low_level  = out_low_q;
  assign level_if.mid_level  = out_mid_q;
  assign level_if.high_level = out_high_q;

  // A product only arrives for an operation that the sequencer issued.
  assert property (@(posedge clk_i) disable iff (!rst_ni) mul_done |-> started_q)
    else $error("multiplier result without a pending operation");

  // The updated peak never falls below the updated envelope of its band.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_PK && mul_done) |=> peak_q[$past(band_q)] >= env_q[$past(band_q)])
    else $error("band peak below band envelope");

  // Levels presented never exceed unity.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    level_if.valid |-> (level_if.low_level <= tbce_pkg::LEVEL_ONE &&
                        level_if.mid_level <= tbce_pkg::LEVEL_ONE &&
                        level_if.high_level <= tbce_pkg::LEVEL_ONE))
    else $error("band level above unity");

endmodule

### bench/tb_three_band_crossover_envelope.sv
// Self-checking testbench of the three-band crossover envelope follower.
`timescale 1ns / 1ps

module tb_three_band_crossover_envelope;

  localparam int SAMPLE_W   = tbce_pkg::SAMPLE_BITS_DEF;
  localparam int ACC_W      = tbce_pkg::ACC_BITS_DEF;
  localparam int HIST_FRAC  = ACC_W - SAMPLE_W - 3;
  localparam int COEF_SHIFT = tbce_pkg::COEF_FRAC - HIST_FRAC;
  localparam int PHASE_ITEMS = 150;
  localparam int NUM_PHASES  = 6;
  localparam logic [tbce_pkg::CFG_IDX_BITS-1:0] UNUSED_REG_INDEX = 8'd200;
  localparam logic [SAMPLE_W-1:0] SAMPLE_MAX = 24'h7FFFFF;
  localparam logic [SAMPLE_W-1:0] SAMPLE_MIN = 24'h800000;

  typedef struct packed {
    logic [tbce_pkg::LEVEL_BITS-1:0] low_level;
    logic [tbce_pkg::LEVEL_BITS-1:0] mid_level;
    logic [tbce_pkg::LEVEL_BITS-1:0] high_level;
  } levels_t;

  typedef struct {
    logic [SAMPLE_W-1:0] sample;
    bit                  reload;
    bit                  known;
    levels_t             levels;
  } stim_row_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;

  tbce_cfg_if    cfg_bus ();
  tbce_sample_if sample_bus ();
  tbce_level_if  level_bus ();

  three_band_crossover_envelope dut (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .cfg_if    (cfg_bus),
    .sample_if (sample_bus),
    .level_if  (level_bus)
  );

  // Clock with an 8 ns period.
  always begin
    #4 clk_i = 1'b1;
    #4 clk_i = 1'b0;
  end

  // Shadow copy of the registers and of the filter, envelope and peak state.
  logic [63:0] shadow_reg [8];
  longint      filt_hist [16];
  logic [63:0] band_env [3];
  logic [63:0] band_pk [3];
  levels_t     pending_levels [$];

  int  error_count = 0;
  int  levels_seen = 0;
  int  samples_sent = 0;
  bit  idling_on = 1'b1;
  int  ready_hold = 0;
  logic [SAMPLE_W-1:0] last_sample = '0;

  task automatic report_mismatch(input string what);
    $display("mismatch at %0t: %s", $time, what);
    error_count++;
  endtask

  function automatic longint clamp_to(input longint v, input int bits);
    longint lim;
    lim = longint'(1) <<< (bits - 1);
    if (v > lim - 1) return lim - 1;
    if (v < -lim) return -lim;
    return v;
  endfunction

  // One transposed direct form II section; updates its two history words.
  function automatic longint run_section(input int idx, input longint b0, input bit hp,
                                         input longint a1, input longint a2, input longint x);
    longint bx, acc, y, t1;
    bx  = (b0 * x) >>> COEF_SHIFT;
    acc = clamp_to(bx + filt_hist[2*idx], ACC_W);
    y   = clamp_to((acc + (longint'(1) <<< (HIST_FRAC - 1))) >>> HIST_FRAC, SAMPLE_W);
    t1  = hp ? -2 * bx : 2 * bx;
    filt_hist[2*idx]   = clamp_to(t1 - ((a1 * y) >>> COEF_SHIFT) + filt_hist[2*idx+1], ACC_W);
    filt_hist[2*idx+1] = clamp_to(bx - ((a2 * y) >>> COEF_SHIFT), ACC_W);
    return y;
  endfunction

  // Envelope follower, peak tracker and normalised level of one band.
  function automatic logic [tbce_pkg::LEVEL_BITS-1:0] band_level(input int b, input longint y);
    logic [63:0] mag, coef, env_n, decayed, pk, ratio;
    mag     = (y < 0) ? 64'(-y) : 64'(y);
    coef    = (mag > band_env[b]) ? shadow_reg[tbce_pkg::REG_ATTACK]
                                  : shadow_reg[tbce_pkg::REG_RELEASE];
    env_n   = (coef * band_env[b] + ((64'd1 << 32) - coef) * mag) >> 32;
    decayed = (band_pk[b] * shadow_reg[tbce_pkg::REG_PEAK_DECAY]) >> 32;
    pk      = (env_n > decayed) ? env_n : decayed;
    band_env[b] = env_n;
    band_pk[b]  = pk;
    if (pk == 0 || pk < shadow_reg[tbce_pkg::REG_NOISE_FLOOR]) return '0;
    ratio = (env_n * 64'd327680) / (64'd7 * pk);
    return (ratio > 64'(tbce_pkg::LEVEL_ONE)) ? tbce_pkg::LEVEL_ONE
                                              : ratio[tbce_pkg::LEVEL_BITS-1:0];
  endfunction

  function automatic levels_t predict_levels(input logic [SAMPLE_W-1:0] s);
    longint x, ub0l, ub0h, ua1, ua2, lb0l, lb0h, la1, la2, lowmid, hi, lo, md;
    levels_t r;
    x    = longint'($signed(s));
    ub0l = longint'($signed(shadow_reg[tbce_pkg::REG_UPPER_NUMER][63:32]));
    ub0h = longint'($signed(shadow_reg[tbce_pkg::REG_UPPER_NUMER][31:0]));
    ua1  = longint'($signed(shadow_reg[tbce_pkg::REG_UPPER_DENOM][63:32]));
    ua2  = longint'($signed(shadow_reg[tbce_pkg::REG_UPPER_DENOM][31:0]));
    lb0l = longint'($signed(shadow_reg[tbce_pkg::REG_LOWER_NUMER][63:32]));
    lb0h = longint'($signed(shadow_reg[tbce_pkg::REG_LOWER_NUMER][31:0]));
    la1  = longint'($signed(shadow_reg[tbce_pkg::REG_LOWER_DENOM][63:32]));
    la2  = longint'($signed(shadow_reg[tbce_pkg::REG_LOWER_DENOM][31:0]));
    lowmid = run_section(1, ub0l, 1'b0, ua1, ua2, run_section(0, ub0l, 1'b0, ua1, ua2, x));
    hi     = run_section(3, ub0h, 1'b1, ua1, ua2, run_section(2, ub0h, 1'b1, ua1, ua2, x));
    lo     = run_section(5, lb0l, 1'b0, la1, la2, run_section(4, lb0l, 1'b0, la1, la2, lowmid));
    md     = run_section(7, lb0h, 1'b1, la1, la2, run_section(6, lb0h, 1'b1, la1, la2, lowmid));
    r.low_level  = band_level(0, lo);
    r.mid_level  = band_level(1, md);
    r.high_level = band_level(2, hi);
    return r;
  endfunction

  // Butterworth crossover pair packed as the numerator and denominator registers.
  task automatic butterworth(input real fc, output logic [63:0] numer, output logic [63:0] denom);
    real w, alpha, a0, cw;
    int lp_b0, hp_b0, a1, a2;
    w     = 2.0 * 3.14159265358979 * fc / 48000.0;
    cw    = $cos(w);
    alpha = $sin(w) / (2.0 * 0.70710678);
    a0    = 1.0 + alpha;
    lp_b0 = int'((1.0 - cw) / 2.0 / a0 * 1073741824.0);
    hp_b0 = int'((1.0 + cw) / 2.0 / a0 * 1073741824.0);
    a1    = int'(-2.0 * cw / a0 * 1073741824.0);
    a2    = int'((1.0 - alpha) / a0 * 1073741824.0);
    numer = {lp_b0, hp_b0};
    denom = {a1, a2};
  endtask

  task automatic write_reg(input logic [tbce_pkg::CFG_IDX_BITS-1:0] idx,
                           input logic [63:0] value);
    cfg_bus.valid <= 1'b1;
    cfg_bus.index <= idx;
    cfg_bus.data  <= value;
    do @(posedge clk_i); while (!(cfg_bus.valid && cfg_bus.ready));
    cfg_bus.valid <= 1'b0;
    case (idx)
      tbce_pkg::REG_UPPER_NUMER, tbce_pkg::REG_UPPER_DENOM,
      tbce_pkg::REG_LOWER_NUMER, tbce_pkg::REG_LOWER_DENOM:
        shadow_reg[idx] = value;
      tbce_pkg::REG_ATTACK, tbce_pkg::REG_RELEASE, tbce_pkg::REG_PEAK_DECAY:
        shadow_reg[idx] = {32'd0, value[31:0]};
      tbce_pkg::REG_NOISE_FLOOR:
        shadow_reg[idx] = {41'd0, value[22:0]};
      default: ;
    endcase
  endtask

  // Withdraw the offer and wait until every expected result has come.
  task automatic wait_drained();
    sample_bus.valid <= 1'b0;
    while (pending_levels.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic load_crossovers(input real upper_fc, input real lower_fc);
    logic [63:0] n, d;
    butterworth(upper_fc, n, d);
    write_reg(tbce_pkg::REG_UPPER_NUMER, n);
    write_reg(tbce_pkg::REG_UPPER_DENOM, d);
    butterworth(lower_fc, n, d);
    write_reg(tbce_pkg::REG_LOWER_NUMER, n);
    write_reg(tbce_pkg::REG_LOWER_DENOM, d);
  endtask

  task automatic load_envelope(input logic [63:0] att, input logic [63:0] rel,
                               input logic [63:0] dec, input logic [63:0] floor_v);
    write_reg(tbce_pkg::REG_ATTACK, att);
    write_reg(tbce_pkg::REG_RELEASE, rel);
    write_reg(tbce_pkg::REG_PEAK_DECAY, dec);
    write_reg(tbce_pkg::REG_NOISE_FLOOR, floor_v);
  endtask

  // Offer one sample; the expectation is queued at the edge it is taken.
  task automatic send_sample(input logic [SAMPLE_W-1:0] s, input bit known, input levels_t lv);
    levels_t p;
    sample_bus.valid  <= 1'b1;
    sample_bus.sample <= s;
    do @(posedge clk_i); while (!(sample_bus.valid && sample_bus.ready));
    p = predict_levels(s);
    pending_levels.push_back(known ? lv : p);
    samples_sent++;
    last_sample = s;
    if (idling_on && $urandom_range(0, 3) == 0) begin
      sample_bus.valid <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk_i);
    end
  endtask

  function automatic logic [SAMPLE_W-1:0] random_sample();
    case ($urandom_range(0, 9))
      0, 1, 2, 3: return SAMPLE_W'($urandom);
      4, 5, 6:    return SAMPLE_W'($urandom_range(0, 8191) - 4096);
      7:          return ($urandom_range(0, 1) != 0) ? SAMPLE_MAX : SAMPLE_MIN;
      8:          return '0;
      default:    return last_sample;
    endcase
  endfunction

  // Output stall pattern: random bursts while idling is allowed.
  always @(posedge clk_i) begin
    if (ready_hold > 0) begin
      ready_hold <= ready_hold - 1;
      level_bus.ready <= 1'b0;
    end else if (idling_on && $urandom_range(0, 7) == 0) begin
      ready_hold <= $urandom_range(0, 5);
      level_bus.ready <= 1'b0;
    end else begin
      level_bus.ready <= 1'b1;
    end
  end

  // Compare each accepted result with the oldest expectation.
  always @(posedge clk_i) begin
    levels_t want;
    if (rst_ni && level_bus.valid && level_bus.ready) begin
      levels_seen++;
      if (pending_levels.size() == 0) begin
        report_mismatch("levels arrived with none expected");
      end else begin
        want = pending_levels.pop_front();
        if (level_bus.low_level !== want.low_level)
          report_mismatch($sformatf("low_level got %0d want %0d",
                                    level_bus.low_level, want.low_level));
        if (level_bus.mid_level !== want.mid_level)
          report_mismatch($sformatf("mid_level got %0d want %0d",
                                    level_bus.mid_level, want.mid_level));
        if (level_bus.high_level !== want.high_level)
          report_mismatch($sformatf("high_level got %0d want %0d",
                                    level_bus.high_level, want.high_level));
      end
    end
  end

  // Safety limit on the whole run.
  initial begin
    #30_000_000;
    $display("timeout with %0d results outstanding", pending_levels.size());
    $display("status: fail");
    $finish;
  end

  // Directed table: silent filters after reset, then steps and extremes.
  stim_row_t directed [] = '{
    '{SAMPLE_MAX, 1'b0, 1'b1, '0},
    '{SAMPLE_MIN, 1'b0, 1'b1, '0},
    '{24'h000000, 1'b0, 1'b1, '0},
    '{24'hFFFFFF, 1'b0, 1'b1, '0},
    '{24'h000001, 1'b0, 1'b1, '0},
    '{SAMPLE_MAX, 1'b1, 1'b0, '0},
    '{SAMPLE_MAX, 1'b0, 1'b0, '0},
    '{SAMPLE_MAX, 1'b0, 1'b0, '0},
    '{SAMPLE_MAX, 1'b0, 1'b0, '0},
    '{SAMPLE_MIN, 1'b0, 1'b0, '0},
    '{SAMPLE_MAX, 1'b0, 1'b0, '0},
    '{SAMPLE_MIN, 1'b0, 1'b0, '0},
    '{SAMPLE_MAX, 1'b0, 1'b0, '0},
    '{24'h000000, 1'b0, 1'b0, '0},
    '{24'h000000, 1'b0, 1'b0, '0},
    '{24'h000001, 1'b0, 1'b0, '0},
    '{24'hFFFFFF, 1'b0, 1'b0, '0},
    '{24'h555555, 1'b0, 1'b0, '0},
    '{24'hAAAAAA, 1'b0, 1'b0, '0}
  };

  initial begin
    logic [63:0] n, d;
    cfg_bus.valid     = 1'b0;
    cfg_bus.index     = '0;
    cfg_bus.data      = '0;
    sample_bus.valid  = 1'b0;
    sample_bus.sample = '0;
    level_bus.ready   = 1'b0;
    for (int i = 0; i < 4; i++) shadow_reg[i] = '0;
    shadow_reg[tbce_pkg::REG_ATTACK]      = 64'(tbce_pkg::ATTACK_RESET);
    shadow_reg[tbce_pkg::REG_RELEASE]     = 64'(tbce_pkg::RELEASE_RESET);
    shadow_reg[tbce_pkg::REG_PEAK_DECAY]  = 64'(tbce_pkg::PEAK_DECAY_RESET);
    shadow_reg[tbce_pkg::REG_NOISE_FLOOR] = 64'(tbce_pkg::NOISE_FLOOR_RESET);
    foreach (filt_hist[i]) filt_hist[i] = 0;
    foreach (band_env[i]) begin
      band_env[i] = '0;
      band_pk[i]  = '0;
    end
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (directed[i]) begin
      if (directed[i].reload) begin
        wait_drained();
        load_crossovers(2000.0, 100.0);
      end
      send_sample(directed[i].sample, directed[i].known, directed[i].levels);
    end

    // Random phases, each under its own register setting.
    for (int ph = 0; ph < NUM_PHASES; ph++) begin
      wait_drained();
      case (ph)
        0: load_envelope(64'(tbce_pkg::ATTACK_RESET), 64'(tbce_pkg::RELEASE_RESET),
                         64'(tbce_pkg::PEAK_DECAY_RESET), 64'(tbce_pkg::NOISE_FLOOR_RESET));
        1: begin
          // Instant envelope, no peak hold, floor at zero so a silent band has zero peak.
          load_envelope(64'd0, 64'd0, 64'd0, 64'd0);
          write_reg(UNUSED_REG_INDEX, {64{1'b1}});
        end
        2: load_envelope({64{1'b1}}, {64{1'b1}}, {64{1'b1}}, {64{1'b1}});
        3: begin
          // Arbitrary coefficients drive the sections into saturation.
          write_reg(tbce_pkg::REG_UPPER_NUMER, {$urandom, $urandom});
          write_reg(tbce_pkg::REG_UPPER_DENOM, {$urandom, $urandom});
          write_reg(tbce_pkg::REG_LOWER_NUMER, {$urandom, $urandom});
          write_reg(tbce_pkg::REG_LOWER_DENOM, {$urandom, $urandom});
          load_envelope({$urandom, $urandom}, {$urandom, $urandom},
                        {$urandom, $urandom}, 64'($urandom_range(0, 8388607)));
        end
        4: begin
          // Full-scale gains on all numerators with well-behaved poles.
          butterworth(1000.0, n, d);
          write_reg(tbce_pkg::REG_UPPER_NUMER, 64'h7FFF_FFFF_8000_0000);
          write_reg(tbce_pkg::REG_UPPER_DENOM, d);
          write_reg(tbce_pkg::REG_LOWER_NUMER, 64'h8000_0000_7FFF_FFFF);
          write_reg(tbce_pkg::REG_LOWER_DENOM, 64'h0);
          load_envelope(64'(tbce_pkg::ATTACK_RESET), 64'(tbce_pkg::RELEASE_RESET),
                        64'(tbce_pkg::PEAK_DECAY_RESET), 64'd1);
        end
        default: begin
          load_crossovers(real'($urandom_range(1000, 6000)), real'($urandom_range(50, 400)));
          load_envelope(64'($urandom_range(32'hF000_0000, 32'hFFFF_FFFF)),
                        64'($urandom_range(32'hFF00_0000, 32'hFFFF_FFFF)),
                        64'($urandom_range(32'hFFF0_0000, 32'hFFFF_FFFF)),
                        64'($urandom_range(0, 20000)));
          idling_on = 1'b0;
        end
      endcase
      for (int k = 0; k < PHASE_ITEMS; k++)
        send_sample(random_sample(), 1'b0, '0);
    end
    sample_bus.valid <= 1'b0;

    fork
      wait (pending_levels.size() == 0);
      repeat (20_000) @(posedge clk_i);
    join_any
    disable fork;
    repeat (1100) @(posedge clk_i);
    if (pending_levels.size() != 0)
      report_mismatch($sformatf("%0d expected results never arrived", pending_levels.size()));

    $display("run covered %0d samples and %0d level results over %0d register settings",
             samples_sent, levels_seen, NUM_PHASES + 2);
    $display("settings included reset defaults, extreme smoothing values and saturating filters");
    if (error_count == 0) begin
      $display("status: pass");
    end else begin
      $display("%0d mismatches", error_count);
      $display("status: fail");
    end
    $finish;
  end

endmodule
